[rtl/sgm_pkg.sv]
// Package for the 3x3x3 Sobel gradient magnitude block.
// Shared constants, register codes, command/status types and weight function.
// No dependencies.
package sgm_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int VOX_W      = 8;
    localparam int MAG_W      = 11;
    localparam int EDGE_W     = 8;
    localparam int DEPTH_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_CFG_W  = 9;

    localparam int G_W       = 14;           // signed gradient accumulator
    localparam int SUM_W     = 26;           // gx^2 + gy^2 + gz^2
    localparam int FRAC_W    = 16;           // 8 fraction bits on the root
    localparam int RAD_W     = SUM_W + FRAC_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SCALE_W   = 15;
    localparam int PROD_W    = ROOT_W + SCALE_W;
    localparam int MAG_SHIFT = 24;
    localparam logic [SCALE_W-1:0] INV_SCALE = 15'd18886;

    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_DEPTH  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // neighbour offset codes: 0 = -1, 1 = 0, 2 = +1
    localparam logic [1:0] OFS_NEG  = 2'd0;
    localparam logic [1:0] OFS_MID  = 2'd1;
    localparam logic [1:0] OFS_POS  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       write;
        logic       nb_issue;
        logic [1:0] ix;
        logic [1:0] iy;
        logic [1:0] iz;
        logic       sq_step;
        logic [1:0] sq_sel;
        logic       root_start;
        logic       scale;
        logic       emit;
    } sgm_cmd_t;

    typedef struct packed {
        logic filling;
        logic root_done;
        logic out_free;
    } sgm_stat_t;

    function automatic logic signed [2:0] smooth_w(input logic [1:0] code);
        logic signed [2:0] w;
        w = (code == OFS_MID) ? 3'sd2 : 3'sd1;
        return w;
    endfunction

    function automatic logic signed [2:0] diff_w(input logic [1:0] code);
        logic signed [2:0] w;
        case (code)
            OFS_NEG: w = -3'sd1;
            OFS_POS: w = 3'sd1;
            default: w = 3'sd0;
        endcase
        return w;
    endfunction

    // separable weight of one neighbour for the gradient along one axis
    function automatic logic signed [3:0] sobel_w(input logic [1:0] axis,
                                                  input logic [1:0] ix,
                                                  input logic [1:0] iy,
                                                  input logic [1:0] iz);
        logic signed [3:0] wx;
        logic signed [3:0] wy;
        logic signed [3:0] wz;
        wx = (axis == AXIS_X) ? 4'(diff_w(ix)) : 4'(smooth_w(ix));
        wy = (axis == AXIS_Y) ? 4'(diff_w(iy)) : 4'(smooth_w(iy));
        wz = (axis == AXIS_Z) ? 4'(diff_w(iz)) : 4'(smooth_w(iz));
        return 4'(wx * wy * wz);
    endfunction

endpackage

[rtl/sgm_ifs.sv]
// Channel interfaces of the Sobel gradient block: voxel input and result output.
// Depends on sgm_pkg.
interface sgm_in_if import sgm_pkg::*;;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [VOX_W-1:0] voxel;

    modport source (output valid, output req_type, output voxel, input ready);
    modport sink   (input valid, input req_type, input voxel, output ready);
endinterface

interface sgm_out_if import sgm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MAG_W-1:0]  magnitude;
    logic [EDGE_W-1:0] edge_byte;
    logic              last;

    modport source (output valid, output magnitude, output edge_byte, output last,
                    input ready);
    modport sink   (input valid, input magnitude, input edge_byte, input last,
                    output ready);
endinterface

[rtl/sobel_3d_gradient_magnitude_top.sv]
// Top level of the 3x3x3 Sobel gradient magnitude block.
// Depends on sgm_pkg, sgm_ifs, sgm_ctrl and sgm_datapath.
//
// Usage:
//   sample_in  carries voxels in raster order (x fastest, then y, then z) or
//              drain ticks (req_type = 1, value taken as zero).
//   result_out carries one magnitude per voxel; last marks the final voxel.
//   cfg_we/cfg_index/cfg_data write the width, height and depth registers;
//   any such write restarts the stream. Write only while the block is idle.
// Timing:
//   The first W*H+W+1 beats of a volume fill the history and give no result.
//   A result therefore trails its voxel by W*H+W+1 beats; send that many
//   drain ticks after the last voxel to flush the volume. Each beat past the
//   fill runs 27 history reads, squaring and a bit-serial square root.
// Reset:
//   Sizes return to 256 x 256 x 256 (clamped to the maximums) and the stream
//   position clears. The history memory is not cleared.
// Back-pressure:
//   A result waits in the output register; the next beat is taken meanwhile
//   and held back only at its own hand-off.
module sobel_3d_gradient_magnitude_top import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sgm_in_if.sink                sample_in,
    sgm_out_if.source             result_out,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    sgm_cmd_t  cmd;
    sgm_stat_t stat;

    sgm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_req_type   (sample_in.req_type),
        .in_voxel      (sample_in.voxel),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (result_out.valid),
        .out_ready     (result_out.ready),
        .out_magnitude (result_out.magnitude),
        .out_edge_byte (result_out.edge_byte),
        .out_last      (result_out.last)
    );
endmodule

[rtl/sgm_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on sgm_pkg.
module sgm_sqrt import sgm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);
    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  op_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  rem_new;

    always_comb
    begin
        rem_sh  = {rem_reg, op_reg[RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_new = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_new[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

[rtl/sgm_ctrl.sv]
// Sequencer of the Sobel gradient block: walks one voxel through write,
// neighbour fetch, squaring, root, scaling and result hand-off. Depends on sgm_pkg.
module sgm_ctrl import sgm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  sgm_stat_t stat,
    output sgm_cmd_t  cmd
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_WRITE = 8'b0000_0010,
        ST_NBR   = 8'b0000_0100,
        ST_FLUSH = 8'b0000_1000,
        ST_SQ    = 8'b0001_0000,
        ST_ROOT  = 8'b0010_0000,
        ST_SCALE = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] ix_reg, ix_next;
    logic [1:0] iy_reg, iy_next;
    logic [1:0] iz_reg, iz_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        iz_next    = iz_reg;
        cmd        = '0;
        cmd.ix     = ix_reg;
        cmd.iy     = iy_reg;
        cmd.iz     = iz_reg;
        cmd.sq_sel = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                ix_next   = OFS_NEG;
                iy_next   = OFS_NEG;
                iz_next   = OFS_NEG;
                state_next = stat.filling ? ST_IDLE : ST_NBR;
            end
            ST_NBR:
            begin
                cmd.nb_issue = 1'b1;
                if (ix_reg != OFS_POS)
                begin
                    ix_next = ix_reg + 1'b1;
                end
                else
                begin
                    ix_next = OFS_NEG;
                    if (iy_reg != OFS_POS)
                    begin
                        iy_next = iy_reg + 1'b1;
                    end
                    else
                    begin
                        iy_next = OFS_NEG;
                        iz_next = iz_reg + 1'b1;
                        if (iz_reg == OFS_POS)
                        begin
                            state_next = ST_FLUSH;
                            cnt_next   = '0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                // wait for the read and accumulate stages to empty
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd1)
                begin
                    state_next = ST_SQ;
                    cnt_next   = '0;
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == AXIS_Z)
                begin
                    state_next = ST_ROOT;
                    cnt_next   = '0;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    cmd.root_start = 1'b1;
                    cnt_next       = 2'd1;
                end
                else if (stat.root_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ix_reg    <= '0;
            iy_reg    <= '0;
            iz_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ix_reg    <= ix_next;
            iy_reg    <= iy_next;
            iz_reg    <= iz_next;
        end
    end
endmodule

[rtl/sgm_datapath.sv]
// Datapath of the Sobel gradient block: size registers, voxel history memory,
// neighbour fetch pipeline, gradient accumulators, root, scaling and output register.
// Depends on sgm_pkg and sgm_sqrt.
module sgm_datapath import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgm_cmd_t              cmd,
    output sgm_stat_t             stat,
    input  logic                  in_req_type,
    input  logic [VOX_W-1:0]      in_voxel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MAG_W-1:0]      out_magnitude,
    output logic [EDGE_W-1:0]     out_edge_byte,
    output logic                  out_last
);
    localparam int HIST_DEPTH = 2 * MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3;
    localparam int AW  = $clog2(HIST_DEPTH);
    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int WHW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SW  = AW + 2;

    // size registers and values derived from them
    logic [XW-1:0]      width_reg;
    logic [YW-1:0]      height_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [WHW-1:0]     wh_reg;
    logic [AW-1:0]      lag_reg;
    logic [AW-1:0]      ring_reg;
    logic [WHW-1:0]     wh_c;
    logic [AW-1:0]      lag_c;

    // stream position
    logic [AW-1:0]      fill_reg;
    logic [AW-1:0]      slot_reg;
    logic [AW-1:0]      center_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic [DEPTH_W-1:0] z_reg;
    logic [VOX_W-1:0]   voxel_reg;

    logic [VOX_W-1:0]   hist_mem [HIST_DEPTH];

    // fetch pipeline
    logic          a_valid_reg, b_valid_reg;
    logic          a_mask_reg, b_mask_reg;
    logic [5:0]    a_tag_reg, b_tag_reg;
    logic [AW-1:0] a_addr_reg;
    logic [VOX_W-1:0] rdata_reg;

    logic signed [G_W-1:0] gx_reg, gy_reg, gz_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [ROOT_W-1:0] root;
    logic              root_done;

    logic [MAG_W-1:0]  out_mag_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    // combinational helpers
    logic [XW-1:0]      w_new;
    logic [YW-1:0]      h_new;
    logic [DEPTH_W-1:0] d_new;
    logic               restart;
    logic [AW-1:0]      slot_inc;
    logic [AW:0]        center_c;
    logic signed [SW-1:0] addr_s;
    logic               x_ok, y_ok, z_ok;
    logic               x_end, y_end, z_end, is_last;
    logic signed [G_W-1:0] s_ext, tx, ty, tz, g_sel;
    logic signed [2*G_W-1:0] sq_full;
    logic [PROD_W-1:0]  prod;

    always_comb
    begin
        w_new = XW'(cfg_data[DIM_CFG_W-1:0]);
        if (cfg_data[DIM_CFG_W-1:0] == '0)
            w_new = XW'(1);
        else if (32'(cfg_data[DIM_CFG_W-1:0]) > 32'(MAX_WIDTH))
            w_new = XW'(MAX_WIDTH);
        h_new = YW'(cfg_data[DIM_CFG_W-1:0]);
        if (cfg_data[DIM_CFG_W-1:0] == '0)
            h_new = YW'(1);
        else if (32'(cfg_data[DIM_CFG_W-1:0]) > 32'(MAX_HEIGHT))
            h_new = YW'(MAX_HEIGHT);
        d_new = (cfg_data == '0) ? DEPTH_W'(1) : cfg_data;
    end

    assign wh_c  = WHW'(width_reg) * WHW'(height_reg);
    assign lag_c = AW'(wh_c) + AW'(width_reg) + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= XW'(MAX_WIDTH < 256 ? MAX_WIDTH : 256);
            height_reg <= YW'(MAX_HEIGHT < 256 ? MAX_HEIGHT : 256);
            depth_reg  <= DEPTH_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VOLUME_WIDTH:  width_reg  <= w_new;
                REG_VOLUME_HEIGHT: height_reg <= h_new;
                REG_VOLUME_DEPTH:  depth_reg  <= d_new;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wh_reg   <= wh_c;
        lag_reg  <= lag_c;
        ring_reg <= {lag_c[AW-2:0], 1'b1};
    end

    assign restart = (cfg_we && (cfg_index == REG_VOLUME_WIDTH
                                 || cfg_index == REG_VOLUME_HEIGHT
                                 || cfg_index == REG_VOLUME_DEPTH))
                     || (cmd.emit && is_last);
    assign slot_inc = (slot_reg + 1'b1 == ring_reg) ? '0 : slot_reg + 1'b1;
    assign center_c = ({1'b0, slot_reg} >= {1'b0, lag_reg})
                      ? {1'b0, slot_reg} - {1'b0, lag_reg}
                      : {1'b0, slot_reg} + {1'b0, ring_reg} - {1'b0, lag_reg};

    assign stat.filling = fill_reg < lag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            slot_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else if (restart)
        begin
            fill_reg <= '0;
            slot_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            if (cmd.write)
            begin
                slot_reg <= slot_inc;
                if (stat.filling)
                    fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                if (!x_end)
                begin
                    x_reg <= x_reg + 1'b1;
                end
                else
                begin
                    x_reg <= '0;
                    if (!y_end)
                    begin
                        y_reg <= y_reg + 1'b1;
                    end
                    else
                    begin
                        y_reg <= '0;
                        z_reg <= z_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            voxel_reg <= in_req_type ? '0 : in_voxel;
        if (cmd.write)
            center_reg <= center_c[AW-1:0];
    end

    // neighbour address and border mask
    always_comb
    begin
        addr_s = $signed(SW'(center_reg));
        case (cmd.ix)
            OFS_NEG: addr_s = addr_s - SW'(1);
            OFS_POS: addr_s = addr_s + SW'(1);
            default: ;
        endcase
        case (cmd.iy)
            OFS_NEG: addr_s = addr_s - $signed(SW'(width_reg));
            OFS_POS: addr_s = addr_s + $signed(SW'(width_reg));
            default: ;
        endcase
        case (cmd.iz)
            OFS_NEG: addr_s = addr_s - $signed(SW'(wh_reg));
            OFS_POS: addr_s = addr_s + $signed(SW'(wh_reg));
            default: ;
        endcase
        if (addr_s < 0)
            addr_s = addr_s + $signed(SW'(ring_reg));
        else if (addr_s >= $signed(SW'(ring_reg)))
            addr_s = addr_s - $signed(SW'(ring_reg));

        x_ok = (cmd.ix == OFS_NEG) ? (x_reg != '0)
             : (cmd.ix == OFS_POS) ? !x_end : 1'b1;
        y_ok = (cmd.iy == OFS_NEG) ? (y_reg != '0)
             : (cmd.iy == OFS_POS) ? !y_end : 1'b1;
        z_ok = (cmd.iz == OFS_NEG) ? (z_reg != '0)
             : (cmd.iz == OFS_POS) ? !z_end : 1'b1;
    end

    assign x_end   = ({1'b0, x_reg} + 1'b1) >= {1'b0, width_reg};
    assign y_end   = ({1'b0, y_reg} + 1'b1) >= {1'b0, height_reg};
    assign z_end   = ({1'b0, z_reg} + 1'b1) >= {1'b0, depth_reg};
    assign is_last = x_end && y_end && z_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= cmd.nb_issue;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
            hist_mem[slot_reg] <= voxel_reg;
        rdata_reg  <= hist_mem[a_addr_reg];
        a_addr_reg <= addr_s[AW-1:0];
        a_mask_reg <= x_ok && y_ok && z_ok;
        a_tag_reg  <= {cmd.iz, cmd.iy, cmd.ix};
        b_mask_reg <= a_mask_reg;
        b_tag_reg  <= a_tag_reg;
    end

    // accumulate weighted neighbours
    always_comb
    begin
        s_ext = $signed({{(G_W-VOX_W){1'b0}}, rdata_reg});
        tx = s_ext * G_W'(sobel_w(AXIS_X, b_tag_reg[1:0], b_tag_reg[3:2], b_tag_reg[5:4]));
        ty = s_ext * G_W'(sobel_w(AXIS_Y, b_tag_reg[1:0], b_tag_reg[3:2], b_tag_reg[5:4]));
        tz = s_ext * G_W'(sobel_w(AXIS_Z, b_tag_reg[1:0], b_tag_reg[3:2], b_tag_reg[5:4]));
        case (cmd.sq_sel)
            AXIS_X:  g_sel = gx_reg;
            AXIS_Y:  g_sel = gy_reg;
            default: g_sel = gz_reg;
        endcase
        sq_full = $signed({{G_W{g_sel[G_W-1]}}, g_sel}) * $signed({{G_W{g_sel[G_W-1]}}, g_sel});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            gx_reg <= '0;
            gy_reg <= '0;
            gz_reg <= '0;
        end
        else if (b_valid_reg && b_mask_reg)
        begin
            gx_reg <= gx_reg + tx;
            gy_reg <= gy_reg + ty;
            gz_reg <= gz_reg + tz;
        end
        if (cmd.sq_step)
            sum_reg <= ((cmd.sq_sel == AXIS_X) ? '0 : sum_reg) + sq_full[SUM_W-1:0];
        if (cmd.scale)
            mag_reg <= prod[MAG_SHIFT +: MAG_W];
    end

    sgm_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand ({sum_reg, {FRAC_W{1'b0}}}),
        .done     (root_done),
        .root     (root)
    );

    assign stat.root_done = root_done;
    assign prod = PROD_W'(root) * PROD_W'(INV_SCALE);

    // output register
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_mag_reg  <= mag_reg;
            out_last_reg <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_magnitude = out_mag_reg;
    assign out_edge_byte = out_mag_reg[EDGE_W-1:0];
    assign out_last      = out_last_reg;
endmodule

[rtl/sgm_checker.sv]
// Port-level checks on the Sobel gradient block, bound to the top level.
// Depends on sgm_pkg and sobel_3d_gradient_magnitude_top.
module sgm_checker import sgm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [MAG_W-1:0]  out_magnitude,
    input logic [EDGE_W-1:0] out_edge_byte,
    input logic              out_last
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_magnitude) && $stable(out_last))
        else $error("result changed while stalled");

    a_edge_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_edge_byte == out_magnitude[EDGE_W-1:0])
        else $error("edge_byte differs from magnitude");

    // one beat at a time: after an accepted beat the input closes
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");
endmodule

bind sobel_3d_gradient_magnitude_top sgm_checker u_sgm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample_in.valid),
    .in_ready      (sample_in.ready),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .out_magnitude (result_out.magnitude),
    .out_edge_byte (result_out.edge_byte),
    .out_last      (result_out.last)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for sobel_3d_gradient_magnitude_top: streams byte volumes in, checks every
// magnitude against a behavioural predictor of the 3x3x3 Sobel gradient.
// Depends on sgm_pkg, sgm_ifs and the block's RTL.
module tb;
    import sgm_pkg::*;

    localparam int  LIMIT_CYCLES = 3_000_000;
    localparam int  SETTLE       = 200;
    localparam int  DIM_MAX      = 256;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam bit  REQ_VOXEL    = 1'b0;
    localparam bit  REQ_DRAIN    = 1'b1;

    typedef struct {
        logic [MAG_W-1:0]  magnitude;
        logic [EDGE_W-1:0] edge_byte;
        logic              last;
    } grad_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sgm_in_if  in_ch ();
    sgm_out_if out_ch ();

    sobel_3d_gradient_magnitude_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (in_ch),
        .result_out (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state
    int vol_w = 256;
    int vol_h = 256;
    int vol_d = 256;
    int lag_beats;
    int fill_beats;
    int ox, oy, oz;
    byte unsigned stream_vox[$];
    grad_res_t grad_due[$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int beats_sent = 0;
    longint cycle_count = 0;

    function automatic longint isqrt(input longint n);
        longint rem;
        longint root;
        longint bitv;
        rem = n;
        root = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > n)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem = rem - (root + bitv);
                root = (root >>> 1) + bitv;
            end
            else
                root = root >>> 1;
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    function automatic int smooth(input int d);
        return (d == 0) ? 2 : 1;
    endfunction

    task automatic restart_stream();
        lag_beats = vol_w * vol_h + vol_w + 1;
        fill_beats = 0;
        ox = 0;
        oy = 0;
        oz = 0;
        stream_vox.delete();
    endtask

    function automatic int clamp_dim(input int v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    task automatic predict_gradient(input bit req, input logic [7:0] vox);
        int gx, gy, gz, idx, s, x, y, z;
        longint sum, root, mag;
        grad_res_t r;
        gx = 0;
        gy = 0;
        gz = 0;
        stream_vox.push_back((req == REQ_DRAIN) ? 8'd0 : vox);
        if (fill_beats < lag_beats)
        begin
            fill_beats++;
            return;
        end
        for (int dz = -1; dz <= 1; dz++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dx = -1; dx <= 1; dx++)
                begin
                    x = ox + dx;
                    y = oy + dy;
                    z = oz + dz;
                    if (x < 0 || x >= vol_w || y < 0 || y >= vol_h || z < 0 || z >= vol_d)
                        continue;
                    idx = x + y * vol_w + z * vol_w * vol_h;
                    s = stream_vox[idx];
                    gx += s * dx * smooth(dy) * smooth(dz);
                    gy += s * smooth(dx) * dy * smooth(dz);
                    gz += s * smooth(dx) * smooth(dy) * dz;
                end
        sum = longint'(gx) * gx + longint'(gy) * gy + longint'(gz) * gz;
        root = isqrt(sum << 16);
        mag = ((root * 18886) >> 24) & 11'h7FF;
        r.magnitude = mag[MAG_W-1:0];
        r.edge_byte = mag[7:0];
        r.last = (ox + 1 >= vol_w) && (oy + 1 >= vol_h) && (oz + 1 >= vol_d);
        grad_due.push_back(r);
        if (r.last)
            restart_stream();
        else if (ox + 1 < vol_w)
            ox++;
        else
        begin
            ox = 0;
            if (oy + 1 < vol_h)
                oy++;
            else
            begin
                oy = 0;
                oz++;
            end
        end
    endtask

    // one beat on sample_in; returns after acceptance
    task automatic send_beat(input bit req, input logic [7:0] vox);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.voxel    <= vox;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        beats_sent++;
        predict_gradient(req, vox);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (grad_due.size() != 0)
            @(posedge clk);
        // fill beats give no result, so allow for work still in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_VOLUME_WIDTH:  vol_w = clamp_dim(data & 16'h1FF, DIM_MAX);
            REG_VOLUME_HEIGHT: vol_h = clamp_dim(data & 16'h1FF, DIM_MAX);
            REG_VOLUME_DEPTH:  vol_d = clamp_dim(data, 65535);
            default: return;
        endcase
        restart_stream();
    endtask

    task automatic set_volume(input int w, input int h, input int d);
        wait_drained();
        write_reg(REG_VOLUME_WIDTH, 16'(w));
        write_reg(REG_VOLUME_HEIGHT, 16'(h));
        write_reg(REG_VOLUME_DEPTH, 16'(d));
    endtask

    function automatic logic [7:0] rand_voxel();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // sends a whole volume and its drain tail; a broken one stops part way
    task automatic send_volume(input bit broken);
        int n;
        int stop;
        n = vol_w * vol_h * vol_d;
        stop = broken ? $urandom_range(n + lag_beats - 1) : n + lag_beats;
        for (int i = 0; i < stop; i++)
        begin
            if (i < n)
                send_beat(($urandom_range(19) == 0) ? REQ_DRAIN : REQ_VOXEL, rand_voxel());
            else
                // beats past the end act as drain ticks whatever their type
                send_beat(($urandom_range(4) == 0) ? REQ_VOXEL : REQ_DRAIN,
                          8'($urandom));
        end
    endtask

    task automatic test_directed();
        set_volume(1, 1, 1);
        send_beat(REQ_VOXEL, 8'd255);
        repeat (3) send_beat(REQ_DRAIN, 8'd255);
        set_volume(2, 2, 2);
        for (int i = 0; i < 8; i++)
            send_beat(REQ_VOXEL, (i % 3 == 0) ? 8'd255 : 8'd0);
        repeat (7) send_beat(REQ_DRAIN, 8'd0);
        // index beyond the register list is ignored
        wait_drained();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_volume(1'b0);
    endtask

    task automatic test_extremes();
        // zero clamps to one
        wait_drained();
        write_reg(REG_VOLUME_WIDTH, 16'h0000);
        write_reg(REG_VOLUME_HEIGHT, 16'd3);
        write_reg(REG_VOLUME_DEPTH, 16'h0000);
        send_volume(1'b0);
        // oversize height clamps to the maximum; only the start of the volume
        // is run, the next write restarts it
        wait_drained();
        write_reg(REG_VOLUME_WIDTH, 16'd1);
        write_reg(REG_VOLUME_HEIGHT, 16'h03FF);
        write_reg(REG_VOLUME_DEPTH, 16'd1);
        repeat (lag_beats + 12) send_beat(REQ_VOXEL, rand_voxel());
        // deepest volume: only its start is run, the next write restarts it
        set_volume(1, 1, 65535);
        repeat (30) send_beat(REQ_VOXEL, rand_voxel());
    endtask

    task automatic test_random(input int beats, input bit hold_off);
        int start;
        int w, h;
        start = beats_sent;
        while (beats_sent - start < beats)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
            h = ($urandom_range(9) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
            set_volume(w, h, $urandom_range(1, 4));
            send_volume($urandom_range(9) == 0);
            if (hold_off)
            begin
                // sender holds until every expected beat has come out
                in_ch.valid <= 1'b0;
                @(posedge clk);
                while (grad_due.size() != 0)
                    @(posedge clk);
                send_volume(1'b0);
                hold_off = 1'b0;
            end
        end
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_VOXEL;
        in_ch.voxel = '0;
        out_ch.ready = 1'b0;
        restart_stream();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 15;
        recv_stall_pct = 80;
        test_directed();
        test_extremes();
        test_random(60, 1'b1);
        send_idle_pct = 80;
        recv_stall_pct = 15;
        test_random(60, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(60, 1'b0);
        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        grad_res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (grad_due.size() == 0)
            begin
                $error("unexpected result beat: magnitude %0d", out_ch.magnitude);
                fail_count++;
            end
            else
            begin
                e = grad_due.pop_front();
                if (out_ch.magnitude !== e.magnitude)
                begin
                    $error("magnitude: expected %0d, got %0d", e.magnitude, out_ch.magnitude);
                    fail_count++;
                end
                if (out_ch.edge_byte !== e.edge_byte)
                begin
                    $error("edge_byte: expected %0d, got %0d", e.edge_byte, out_ch.edge_byte);
                    fail_count++;
                end
                if (out_ch.last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, out_ch.last);
                    fail_count++;
                end
            end
        end
    end
endmodule

[filelist.f]
rtl/sgm_pkg.sv
rtl/sgm_ifs.sv
rtl/sgm_sqrt.sv
rtl/sgm_ctrl.sv
rtl/sgm_datapath.sv
rtl/sobel_3d_gradient_magnitude_top.sv
rtl/sgm_checker.sv
tb/sv/tb.sv
